// ----- rtl/core/uer_pkg.sv -----
package uer_pkg;

	// Field and register widths
	localparam int COUNTER_WIDTH_DEF = 24;
	localparam int TICK_NS_W = 20;
	localparam int TRIG_W = 16;
	localparam int TMO_W = 24;
	localparam int STATUS_W = 2;
	localparam int DIST_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 24;

	// tick_ns is multiplied in two halves
	localparam int HALF_W = TICK_NS_W / 2;

	// Register reset values
	localparam logic [TICK_NS_W-1:0] TICK_NS_RST = TICK_NS_W'(1000);
	localparam logic [TRIG_W-1:0] TRIG_RST = TRIG_W'(10);
	localparam logic [TMO_W-1:0] TMO_RST = TMO_W'(30000);

	// Range limit and distance scaling: mm = ns * 347 / 2000000
	localparam int PULSE_W = 24;
	localparam logic [PULSE_W-1:0] MAX_PULSE_NS = PULSE_W'(12539185);
	localparam int SPEED_W = 9;
	localparam logic [SPEED_W-1:0] SPEED_NUM = SPEED_W'(347);
	localparam int SCALE_W = PULSE_W + SPEED_W;
	// 2000000 = 2^7 * 15625; divide by 15625 via ceil(2^39 / 15625)
	localparam int DIV_PRE = 7;
	localparam int QUOT_W = SCALE_W - DIV_PRE;
	localparam int RECIP_W = 26;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(35184373);
	localparam int RECIP_SHIFT = 39;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_NS = 2'd0,
		REG_TRIG = 2'd1,
		REG_TMO = 2'd2
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_RANGE = 2'd2
	} res_status_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_CLEAR = 2'd1,
		CNT_ONE = 2'd2,
		CNT_INC = 2'd3
	} cnt_op_t;

	// Controller to datapath
	typedef struct packed {
		cnt_op_t cnt_op;
		logic mul_lo;
		logic mul_hi;
		logic add_hi;
		logic scale;
		logic load_res;
		logic finish_meas;
		logic res_trig;
		logic res_busy;
		logic res_done;
		res_status_t res_status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic trig_first;
		logic trig_hit;
		logic tmo_hit;
	} dp_status_t;

endpackage

// ----- rtl/core/uer_datapath.sv -----
module uer_datapath
	import uer_pkg::*;
#(
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output dp_status_t            sts,
	output logic [M_DATA_W-1:0]   res_data
);

	localparam int CW = COUNTER_WIDTH;
	localparam int CMPW = (CW > TMO_W) ? CW : TMO_W;
	localparam int PW = CW + HALF_W;
	localparam int NSW = CW + TICK_NS_W;
	localparam int QPW = QUOT_W + RECIP_W;

	logic [TICK_NS_W-1:0] tick_ns_q;
	logic [TRIG_W-1:0]    trig_q;
	logic [TMO_W-1:0]     tmo_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_inc;
	logic                 cnt_max_hit;
	logic [CMPW-1:0]      tmo_lim;
	logic [PW-1:0]        prod;
	logic [PW-1:0]        prod_q;
	logic [NSW-1:0]       acc_q;
	logic                 range_q;
	logic [SCALE_W-1:0]   x_q;
	logic [QPW-1:0]       q_prod;
	logic [DIST_W-1:0]    mm_quot;
	logic                 r_trig_q;
	logic                 r_busy_q;
	logic                 r_done_q;
	logic [STATUS_W-1:0]  r_status_q;
	logic [DIST_W-1:0]    r_dist_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ns_q <= TICK_NS_RST;
			trig_q <= TRIG_RST;
			tmo_q <= TMO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_NS: tick_ns_q <= cfg_data[TICK_NS_W-1:0];
				REG_TRIG:    trig_q <= cfg_data[TRIG_W-1:0];
				REG_TMO:     tmo_q <= cfg_data[TMO_W-1:0];
				default:     ;
			endcase
		end
	end

	// Saturating tick counter and its limit checks
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CW'(1);
	assign cnt_max_hit = (cnt_inc == '1);
	assign tmo_lim = (tmo_q == '0) ? CMPW'(1) : CMPW'(tmo_q);

	assign sts.trig_first = (trig_q <= TRIG_W'(1));
	assign sts.trig_hit = (CMPW'(cnt_inc) >= CMPW'(trig_q)) || cnt_max_hit;
	assign sts.tmo_hit = (CMPW'(cnt_inc) >= tmo_lim) || cnt_max_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_CLEAR: cnt_q <= '0;
				CNT_ONE:   cnt_q <= CW'(1);
				CNT_INC:   cnt_q <= cnt_inc;
				default:   ;
			endcase
		end
	end

	// Pulse time in ns: count times tick_ns, one half of tick_ns per pass
	assign prod = cmd.mul_lo ? PW'(cnt_q) * PW'(tick_ns_q[HALF_W-1:0])
	                         : PW'(cnt_q) * PW'(tick_ns_q[TICK_NS_W-1:HALF_W]);

	always_ff @(posedge clk) begin
		if (cmd.mul_lo)
			acc_q <= NSW'(prod);
		if (cmd.mul_hi)
			prod_q <= prod;
		if (cmd.add_hi)
			acc_q <= acc_q + {prod_q, {HALF_W{1'b0}}};
		if (cmd.scale) begin
			range_q <= (acc_q > NSW'(MAX_PULSE_NS));
			x_q <= SCALE_W'(acc_q[PULSE_W-1:0]) * SCALE_W'(SPEED_NUM);
		end
	end

	// Divide by 2000000: drop the power of two, then reciprocal multiply
	assign q_prod = QPW'(x_q[SCALE_W-1:DIV_PRE]) * QPW'(RECIP_M);
	assign mm_quot = q_prod[RECIP_SHIFT +: DIST_W];

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			r_trig_q <= cmd.res_trig;
			r_busy_q <= cmd.res_busy;
			r_done_q <= cmd.res_done;
			if (cmd.finish_meas) begin
				r_status_q <= range_q ? ST_RANGE : ST_OK;
				r_dist_q <= range_q ? '0 : mm_quot;
			end else begin
				r_status_q <= cmd.res_status;
				r_dist_q <= '0;
			end
		end
	end

	assign res_data = {{(M_DATA_W - DIST_W - STATUS_W - 3){1'b0}},
	                   r_dist_q, r_status_q, r_done_q, r_busy_q, r_trig_q};

endmodule

// ----- rtl/core/uer_ctrl.sv -----
module uer_ctrl
	import uer_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       start,
	input  logic       echo,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t sts,
	output cmd_t       cmd
);

	typedef enum logic [5:0] {
		C_TAKE   = 6'b000001,
		C_MUL_LO = 6'b000010,
		C_MUL_HI = 6'b000100,
		C_ADD    = 6'b001000,
		C_SCALE  = 6'b010000,
		C_DIV    = 6'b100000
	} ctrl_state_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_TRIG = 4'b0010,
		PH_RISE = 4'b0100,
		PH_FALL = 4'b1000
	} phase_t;

	ctrl_state_t state_q, state_d;
	phase_t      phase_q, phase_d;
	logic        out_valid_q;
	logic        accept;

	assign in_ready = (state_q == C_TAKE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Per-tick decisions and arithmetic sequencing
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd = '0;
		cmd.cnt_op = CNT_HOLD;
		cmd.res_status = ST_OK;

		unique case (state_q)
			C_TAKE: begin
				if (accept) begin
					cmd.load_res = 1'b1;
					unique case (phase_q)
						PH_IDLE: begin
							if (start) begin
								cmd.res_trig = 1'b1;
								if (sts.trig_first) begin
									phase_d = PH_RISE;
									cmd.cnt_op = CNT_CLEAR;
								end else begin
									phase_d = PH_TRIG;
									cmd.cnt_op = CNT_ONE;
								end
							end
						end
						PH_TRIG: begin
							cmd.res_trig = 1'b1;
							if (sts.trig_hit) begin
								phase_d = PH_RISE;
								cmd.cnt_op = CNT_CLEAR;
							end else begin
								cmd.cnt_op = CNT_INC;
							end
						end
						PH_RISE: begin
							if (echo) begin
								phase_d = PH_FALL;
								cmd.cnt_op = CNT_ONE;
							end else if (sts.tmo_hit) begin
								phase_d = PH_IDLE;
								cmd.cnt_op = CNT_CLEAR;
								cmd.res_done = 1'b1;
								cmd.res_status = ST_TIMEOUT;
							end else begin
								cmd.cnt_op = CNT_INC;
							end
						end
						PH_FALL: begin
							if (!echo) begin
								// hold the result back until the distance is ready
								phase_d = PH_IDLE;
								cmd.load_res = 1'b0;
								state_d = C_MUL_LO;
							end else if (sts.tmo_hit) begin
								phase_d = PH_IDLE;
								cmd.cnt_op = CNT_CLEAR;
								cmd.res_done = 1'b1;
								cmd.res_status = ST_TIMEOUT;
							end else begin
								cmd.cnt_op = CNT_INC;
							end
						end
						default: ;
					endcase
					cmd.res_busy = (phase_d != PH_IDLE);
				end
			end
			C_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d = C_MUL_HI;
			end
			C_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d = C_ADD;
			end
			C_ADD: begin
				cmd.add_hi = 1'b1;
				state_d = C_SCALE;
			end
			C_SCALE: begin
				cmd.scale = 1'b1;
				state_d = C_DIV;
			end
			C_DIV: begin
				cmd.load_res = 1'b1;
				cmd.finish_meas = 1'b1;
				cmd.res_done = 1'b1;
				cmd.cnt_op = CNT_CLEAR;
				state_d = C_TAKE;
			end
			default: state_d = C_TAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_TAKE;
			phase_q <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			// present a loaded result until it is taken
			if (cmd.load_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/ultrasonic_echo_ranging.sv -----
// Ultrasonic echo ranging controller. Every request on the input stream is one
// time tick carrying a start flag (bit 0) and the sampled echo level (bit 1);
// every request yields exactly one result giving the trigger line level, busy,
// done, a status (ok, timeout, out of range) and the one-way distance in mm.
// A start while idle raises the trigger for trigger_ticks ticks, then the echo
// rise and the echo pulse are each timed against timeout_ticks. A request is
// taken only when the previous result is taken or already gone. The tick that
// ends an echo pulse holds off further requests while the arithmetic sequence
// runs: two partial products of count x tick_ns, their sum, the range check
// with the x347 scale, and the reciprocal divide by 2000000. Configuration
// writes are taken every cycle and must be issued only while the block is idle.
module ultrasonic_echo_ranging
	import uer_pkg::*;
#(
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // command, echo_level
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // trigger_level, busy_res, done_res,
	                                         // status[1:0], range_mm[11:0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t       cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	uer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.start     (s_tdata[0]),
		.echo      (s_tdata[1]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	uer_datapath #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_data  (m_tdata)
	);

endmodule
